FILE: sv/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types, sizes and codes for the streaming KMP matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // Sizes
  localparam int PATTERN_MAX   = 64;
  localparam int POSITION_BITS = 32;
  localparam int CHAR_W        = 8;
  localparam int START_W       = 32;
  localparam int IDX_W         = $clog2(PATTERN_MAX);
  localparam int CNT_W         = $clog2(PATTERN_MAX + 1);

  // Item commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CHAR_W-1:0] char_value;
  } kmp_in_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic [1:0]         status;
  } kmp_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the accepted item, issue the first table read
    logic step;        // evaluate one compare / fallback step
    logic wrap;        // full match: take the fallback length from the table
    logic fin_direct;  // load the output register from the current result
    logic fin_save;    // park the current result while the output is stalled
    logic fin_saved;   // load the output register from the parked result
  } kmp_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic exec_done;   // item completes in this step
    logic need_wrap;   // text byte completed the pattern
    logic out_free;    // output register can take a result this cycle
  } kmp_sts_t;

endpackage

FILE: sv/kmp_ram.sv
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kmp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer for the KMP matcher: accepts an item, walks the failure table
// one step per cycle, and hands the result to the output register.
// ----------------------------------------------------------------------------
module kmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmp_pkg::kmp_sts_t sts,
  output kmp_pkg::kmp_ctl_t ctl
);

  import kmp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WRAP = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.step = 1'b1;
        if (sts.need_wrap) begin
          state_nxt = S_WRAP;
        end else if (sts.exec_done) begin
          if (sts.out_free) begin
            ctl.fin_direct = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            ctl.fin_save = 1'b1;
            state_nxt    = S_HOLD;
          end
        end
      end
      S_WRAP: begin
        ctl.wrap = 1'b1;
        if (sts.out_free) begin
          ctl.fin_direct = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ctl.fin_save = 1'b1;
          state_nxt    = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts.out_free) begin
          ctl.fin_saved = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/kmp_dpath.sv
// ----------------------------------------------------------------------------
// kmp_dpath
// Datapath for the KMP matcher: pattern and failure RAMs, match state,
// text position counter and the output register.
// ----------------------------------------------------------------------------
module kmp_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  kmp_pkg::kmp_in_t  in_data,
  input  kmp_pkg::kmp_ctl_t ctl,
  output kmp_pkg::kmp_sts_t sts,
  input  logic              out_stall,
  output logic              out_valid,
  output kmp_pkg::kmp_out_t out_data
);

  import kmp_pkg::*;

  // Item and match state
  logic [1:0]               op_r;
  logic [CHAR_W-1:0]        char_r;
  logic [IDX_W-1:0]         len_r,     len_nxt;
  logic [IDX_W-1:0]         build_r,   build_nxt;
  logic [IDX_W-1:0]         matched_r, matched_nxt;
  logic [CNT_W-1:0]         count_r,   count_nxt;
  logic [POSITION_BITS-1:0] pos_r,     pos_nxt;
  kmp_out_t                 res_r,     res_nxt;
  kmp_out_t                 out_r,     out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  fail_wdata;
  logic [IDX_W-1:0]  pat_raddr;
  logic [IDX_W-1:0]  fail_raddr;
  logic [CHAR_W-1:0] pat_rdata;
  logic [IDX_W-1:0]  fail_rdata;

  // Decode and compare
  logic                     is_clear, is_append, is_text;
  logic                     pat_full, pat_empty, loop_op;
  logic                     hit, step_end, full_hit, commit;
  logic [CNT_W-1:0]         j_len, count_m1;
  logic [IDX_W-1:0]         start_len, fail_base;
  logic [POSITION_BITS-1:0] first_pos;
  logic [POSITION_BITS+START_W-1:0] first_ext;
  kmp_out_t                 res;

  kmp_ram #(
    .WIDTH  (CHAR_W),
    .DEPTH  (PATTERN_MAX),
    .ADDR_W (IDX_W)
  ) u_pat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (char_r),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  kmp_ram #(
    .WIDTH  (IDX_W),
    .DEPTH  (PATTERN_MAX),
    .ADDR_W (IDX_W)
  ) u_fail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (fail_wdata),
    .raddr (fail_raddr),
    .rdata (fail_rdata)
  );

  // Decode the held item and evaluate one table step
  always_comb begin
    is_clear  = (op_r == CMD_CLEAR);
    is_append = (op_r == CMD_APPEND);
    is_text   = (op_r == CMD_TEXT);
    pat_full  = (count_r == CNT_W'(PATTERN_MAX));
    pat_empty = (count_r == '0);
    loop_op   = (is_append && !pat_full && !pat_empty) || (is_text && !pat_empty);
    hit       = (pat_rdata == char_r);
    step_end  = hit || (len_r == '0);
    j_len     = hit ? (CNT_W'(len_r) + CNT_W'(1)) : '0;
    full_hit  = is_text && (j_len == count_r);
    count_m1  = count_r - CNT_W'(1);

    sts.need_wrap = loop_op && step_end && full_hit;
    sts.exec_done = !loop_op || (step_end && !full_hit);
    sts.out_free  = !out_valid_r || !out_stall;
    commit        = ctl.step && sts.exec_done;
  end

  // Table read addresses: start length on capture, fallback length while walking, last pattern entry on a full match
  always_comb begin
    start_len = (in_data.cmd == CMD_APPEND) ? build_r : matched_r;
    pat_raddr = ctl.step ? fail_rdata : start_len;
    fail_base = ctl.step ? fail_rdata : start_len;
    if (ctl.step && sts.need_wrap) begin
      fail_raddr = count_m1[IDX_W-1:0];
    end else if (fail_base == '0) begin
      fail_raddr = '0;
    end else begin
      fail_raddr = fail_base - IDX_W'(1);
    end
  end

  // Append write: new byte and its failure entry at the pattern tail
  always_comb begin
    ram_we     = commit && is_append && !pat_full;
    ram_waddr  = count_r[IDX_W-1:0];
    fail_wdata = pat_empty ? '0 : j_len[IDX_W-1:0];
  end

  // Result of the item in flight
  always_comb begin
    first_pos         = pos_r - POSITION_BITS'(count_r) + POSITION_BITS'(1);
    first_ext         = {{START_W{1'b0}}, first_pos};
    res.match_found   = ctl.wrap;
    res.match_start   = ctl.wrap ? first_ext[START_W-1:0] : '0;
    if (is_append && pat_full) begin
      res.status = ST_FULL;
    end else if (is_text && pat_empty) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_OK;
    end
  end

  // Next state of the match registers
  always_comb begin
    len_nxt     = len_r;
    build_nxt   = build_r;
    matched_nxt = matched_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    if (ctl.capture) begin
      len_nxt = start_len;
    end else if (ctl.step && loop_op && !step_end) begin
      // fall back through the failure table
      len_nxt = fail_rdata;
    end
    if (commit) begin
      if (is_clear) begin
        build_nxt   = '0;
        matched_nxt = '0;
        count_nxt   = '0;
        pos_nxt     = '0;
      end else if (is_append && !pat_full) begin
        build_nxt = fail_wdata;
        count_nxt = count_r + CNT_W'(1);
      end else if (is_text) begin
        if (!pat_empty) begin
          matched_nxt = j_len[IDX_W-1:0];
        end
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
    end
    if (ctl.wrap) begin
      matched_nxt = fail_rdata;
      pos_nxt     = pos_r + POSITION_BITS'(1);
    end
  end

  // Output register and parked result
  always_comb begin
    out_nxt       = out_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.fin_save) begin
      res_nxt = res;
    end
    if (ctl.fin_direct) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (ctl.fin_saved) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  // Control and match state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_r     <= '0;
      matched_r   <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      build_r     <= build_nxt;
      matched_r   <= matched_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r   <= in_data.cmd;
      char_r <= in_data.char_value;
    end
    len_r <= len_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/kmp_stream_matcher.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming Knuth-Morris-Pratt matcher with incremental failure table build.
//
// Input transfer (in_valid / in_stall, in_data): cmd clear empties the
// pattern and the match state, cmd append adds one pattern byte and extends
// the failure table, cmd text feeds one text byte. Every item gives exactly
// one result transfer (out_valid / out_stall, out_data) with match_found,
// match_start (index of the occurrence's first byte) and status.
// An accepted item is latched with its first table reads issued. Each compare
// either settles it and hands on the result, or falls back one entry
// through the failure table; a text byte that completes the pattern takes
// one more step for the overlap fallback read. The pattern and failure RAMs
// are walked one entry per cycle on one read port each.
// in_stall is low only while the sequencer is idle. A finished result waits
// in the output register while the receiver stalls, and the next item is
// still accepted; a second result parks until the output register drains.
// Reset (rst_n low, synchronous) empties the pattern and zeroes the match
// length and text position; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module kmp_stream_matcher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmp_pkg::kmp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kmp_pkg::kmp_out_t out_data
);

  import kmp_pkg::*;

  kmp_ctl_t ctl;
  kmp_sts_t sts;

  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  kmp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
